@@ hw/rtl/bdeq_pkg.sv @@
package bdeq_pkg;

    // Ring store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Field widths fixed by the interface
    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int CAP_W  = 5;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int IN_W  = 40;
    localparam int OUT_W = 72;

    // Bit positions inside the result tdata
    localparam int RES_OK_BIT    = 0;
    localparam int RES_FRONT_LSB = 1;
    localparam int RES_REAR_LSB  = 33;
    localparam int RES_EMPTY_BIT = 65;
    localparam int RES_FULL_BIT  = 66;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK       = 3'd4
    } op_t;

    // One result, last field in the lowest bits
    typedef struct packed {
        logic              now_full;
        logic              now_empty;
        logic [WORD_W-1:0] rear_value;
        logic [WORD_W-1:0] front_value;
        logic              accepted;
    } result_t;

endpackage

@@ hw/rtl/bdeq_ram.sv @@
module bdeq_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32,
    parameter int WORDS  = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [DATA_W-1:0] rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports, old data on a same-address write
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ hw/rtl/bounded_double_ended_queue_top.sv @@
// An accepted transaction is registered into the index, count and store read
// data, then into the output register. The block takes no new item while the
// store's registered read of the new front and rear entries is in progress.
// A result stalled on the output holds off the next item until it is taken.
// Reset (aresetn low, synchronous): queue empty, front index zero, capacity
// at full depth, no result pending. The store itself is not cleared.
module bounded_double_ended_queue_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [2:0] operation, [34:3] item_value, [39:35] zero
    input  logic [bdeq_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] accepted, [32:1] front_value, [64:33] rear_value,
    // [65] now_empty, [66] now_full, [71:67] zero
    output logic [bdeq_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_wen,
    input  logic [bdeq_pkg::CAP_W-1:0] cfg_wdata
);

    import bdeq_pkg::*;

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic              busy_reg;
    logic              ok_reg, ok_next;
    logic              fwd_front_reg, fwd_rear_reg;
    logic [WORD_W-1:0] wdata_reg;
    logic              m_valid_reg;
    result_t           m_data_reg;

    logic              in_fire;
    op_t               op;
    logic [WORD_W-1:0] in_value;
    logic              full, empty;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rear_addr;
    logic [SUM_W-1:0]  push_sum, rear_sum;
    logic [WORD_W-1:0] rd_front, rd_rear;
    logic [CMP_W-1:0]  cfg_ext;
    result_t           res;

    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign in_value = s_tdata[OP_W +: WORD_W];

    assign full  = count_reg >= cap_reg;
    assign empty = count_reg == '0;

    // Rear slot for an insert at the rear: front plus count, wrapped once
    assign push_sum = SUM_W'(front_reg) + SUM_W'(count_reg);

    // Apply the operation to the index and count
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        unique case (op)
            OP_PUSH_FRONT: begin
                if (!full) begin
                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                   : front_reg - 1'b1;
                    wr_addr    = front_next;
                    wr_en      = in_fire;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (!full) begin
                    wr_addr    = (push_sum >= SUM_W'(DEPTH))
                               ? IDX_W'(push_sum - SUM_W'(DEPTH))
                               : IDX_W'(push_sum);
                    wr_en      = in_fire;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!empty) begin
                    front_next = (front_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                  : front_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (!empty) begin
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_PEEK: begin
                ok_next = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Rear entry after the operation; meaningless when the queue ends empty
    assign rear_sum  = SUM_W'(front_next) + SUM_W'(count_next) - 1'b1;
    assign rear_addr = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(rear_sum);

    bdeq_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_value),
        .rd_addr_a (front_next),
        .rd_data_a (rd_front),
        .rd_addr_b (rear_addr),
        .rd_data_b (rd_rear)
    );

    // Commit index and count, latch forwarding for the read cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            busy_reg <= in_fire;
            if (in_fire) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ok_reg        <= ok_next;
            wdata_reg     <= in_value;
            fwd_front_reg <= wr_en && (wr_addr == front_next);
            fwd_rear_reg  <= wr_en && (wr_addr == rear_addr);
        end
    end

    // Capacity register, saturated to the depth, taken only while empty
    assign cfg_ext = CMP_W'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(DEPTH);
        end else if (cfg_wen && (count_reg == '0)) begin
            cap_reg <= (cfg_ext > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cfg_wdata);
        end
    end

    // Assemble the result from read data or the word just written, or all ones when empty
    always_comb begin
        res.accepted    = ok_reg;
        res.now_empty   = count_reg == '0;
        res.now_full    = count_reg >= cap_reg;
        res.front_value = fwd_front_reg ? wdata_reg : rd_front;
        res.rear_value  = fwd_rear_reg ? wdata_reg : rd_rear;
        if (count_reg == '0) begin
            res.front_value = '1;
            res.rear_value  = '1;
        end
    end

    // Output register: load in the read cycle, drop on a completed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (busy_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, m_data_reg};

endmodule

@@ hw/rtl/bdeq_checker.sv @@
module bdeq_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bdeq_pkg::OUT_W-1:0] m_tdata
);

    import bdeq_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no accept right after an accept
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in flight");

    // Every accepted transaction shows its result once the output register loads
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing two cycles after accept");

    // An empty queue reports minus one at both ends
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_EMPTY_BIT] |->
            (m_tdata[RES_FRONT_LSB +: WORD_W] == '1) &&
            (m_tdata[RES_REAR_LSB +: WORD_W] == '1))
        else $error("empty queue reports a value");

endmodule

bind bounded_double_ended_queue_top bdeq_checker u_bdeq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/bounded_double_ended_queue_top_tb.sv @@
module bounded_double_ended_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdeq_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 2;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 230;
    localparam int BIAS_RUN       = 24;
    localparam int RUN_LIMIT_NS   = 5_000_000;

    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_PEEK + 1);
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    // Shadow copy of the ring store: predicts one result per operation
    class deque_shadow;
        logic [WORD_W-1:0] ring [DEPTH];
        int unsigned       head;
        int unsigned       fill;
        int unsigned       cap;
        result_t           pending_snapshots [$];
        int                errors;
        int                n_sent;
        int                n_checked;
        int                n_refused;
        int                n_full;

        function new();
            foreach (ring[i]) ring[i] = '0;
            head = 0;
            fill = 0;
            cap  = DEPTH;
        endfunction

        // Take a capacity write; ignored while entries are held
        function void load_capacity(logic [CAP_W-1:0] v);
            if (fill != 0) return;
            cap = (v > DEPTH) ? DEPTH : v;
        endfunction

        // Apply one operation and queue the snapshot it should report
        function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] value);
            result_t snap;
            logic    is_full;
            logic    is_empty;
            is_full  = (fill >= cap);
            is_empty = (fill == 0);
            snap     = '0;
            case (op)
                OP_PUSH_FRONT: if (!is_full) begin
                    head       = (head + DEPTH - 1) % DEPTH;
                    ring[head] = value;
                    fill++;
                    snap.accepted = 1'b1;
                end
                OP_PUSH_REAR: if (!is_full) begin
                    ring[(head + fill) % DEPTH] = value;
                    fill++;
                    snap.accepted = 1'b1;
                end
                OP_POP_FRONT: if (!is_empty) begin
                    head = (head + 1) % DEPTH;
                    fill--;
                    snap.accepted = 1'b1;
                end
                OP_POP_REAR: if (!is_empty) begin
                    fill--;
                    snap.accepted = 1'b1;
                end
                OP_PEEK: snap.accepted = 1'b1;
                default: ;
            endcase
            snap.front_value = '1;
            snap.rear_value  = '1;
            if (fill != 0) begin
                snap.front_value = ring[head];
                snap.rear_value  = ring[(head + fill - 1) % DEPTH];
            end
            snap.now_empty = (fill == 0);
            snap.now_full  = (fill >= cap);
            n_sent++;
            if (!snap.accepted) n_refused++;
            if (snap.now_full) n_full++;
            pending_snapshots.push_back(snap);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got) begin
                errors++;
                $error("%s mismatch: expected %h, actual %h", name, want, got);
            end
        endfunction

        // Compare one result transaction against the oldest snapshot
        function void check_result(result_t got);
            result_t want;
            if (pending_snapshots.size() == 0) begin
                errors++;
                $error("result transaction with nothing outstanding: %h", got);
                return;
            end
            want = pending_snapshots.pop_front();
            n_checked++;
            compare_field("accepted", WORD_W'(want.accepted), WORD_W'(got.accepted));
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("rear_value", want.rear_value, got.rear_value);
            compare_field("now_empty", WORD_W'(want.now_empty), WORD_W'(got.now_empty));
            compare_field("now_full", WORD_W'(want.now_full), WORD_W'(got.now_full));
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_wen   = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata = '0;

    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    deque_shadow        shadow    = new();

    int                 idle_plan  [4] = '{0, 74, 0, 10};
    int                 stall_plan [4] = '{0, 0, 74, 10};
    logic [CAP_W-1:0]   cap_plan   [4] = '{'1, CAP_W'(5), CAP_W'(1), CAP_W'(DEPTH)};

    bounded_double_ended_queue_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_result(m_tdata[$bits(result_t)-1:0]);
    end

    // Offer one operation, idling first at random, and hold until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - OP_W - WORD_W){1'b0}}, value, op};
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(op, value);
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (shadow.pending_snapshots.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        settle();
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        shadow.load_capacity(v);
    endtask

    // Remove whatever is held, from either end
    task automatic drain_queue();
        int n;
        settle();
        n = shadow.fill;
        repeat (n) send_item($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR, $urandom);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        if ($urandom_range(15) != 0) return $urandom;
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            default: return '0;
        endcase
    endfunction

    // Random operations in runs that lean towards filling or emptying
    task automatic random_burst(input int count);
        int              insert_pct;
        int              pick;
        logic [OP_W-1:0] op;
        insert_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % BIAS_RUN == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 3)
                op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
            else if (pick < 10)
                op = OP_PEEK;
            else if ($urandom_range(99) < insert_pct)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            send_item(op, random_word());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty queue: peek, refused removals, undefined codes
        send_item(OP_PEEK, $urandom);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_REAR, $urandom);
        send_item(OP_FIRST_UNUSED, '1);
        send_item(OP_LAST_UNUSED, $urandom);

        // Extreme words at both ends
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(OP_PUSH_REAR, 32'h8000_0000);
        send_item(OP_PUSH_FRONT, '1);
        send_item(OP_PUSH_REAR, '0);
        send_item(OP_PEEK, $urandom);
        send_item(OP_LAST_UNUSED, '1);

        // Capacity write while entries are held must be ignored
        set_capacity(2);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_REAR, $urandom);
        drain_queue();

        // Zero capacity: empty and full at once, every insert and removal refused
        set_capacity('0);
        send_item(OP_PUSH_FRONT, $urandom);
        send_item(OP_PUSH_REAR, $urandom);
        send_item(OP_POP_FRONT, $urandom);
        send_item(OP_POP_REAR, $urandom);
        send_item(OP_PEEK, $urandom);

        // Small capacity: fill up, then refuse inserts at both ends
        set_capacity(3);
        send_item(OP_PUSH_REAR, $urandom);
        send_item(OP_PUSH_REAR, $urandom);
        send_item(OP_PUSH_FRONT, $urandom);
        send_item(OP_PUSH_FRONT, $urandom);
        send_item(OP_PUSH_REAR, $urandom);

        // Random phases under different idle and stall mixes
        for (int p = 0; p < 4; p++) begin
            drain_queue();
            set_capacity(cap_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            random_burst(PHASE_ITEMS);
        end

        settle();
        $display("Deque run: %0d operations sent, %0d results checked, %0d refused, %0d full.",
                 shadow.n_sent, shadow.n_checked, shadow.n_refused, shadow.n_full);
        $display("Capacities 0, 1, 3, 5, full depth and a saturating write, four idle/stall mixes.");
        if (shadow.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bdeq_pkg.sv
hw/rtl/bdeq_ram.sv
hw/rtl/bounded_double_ended_queue_top.sv
hw/rtl/bdeq_checker.sv
tb/bounded_double_ended_queue_top_tb.sv
